@@ sv/obb_collision_sat_mtv_core_defines.svh @@
// assertion macros for the collision core
`ifndef OBB_COLLISION_SAT_MTV_CORE_DEFINES_SVH
`define OBB_COLLISION_SAT_MTV_CORE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define OBB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked at the next clock edge, outside reset
`define OBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/obb_pkg.sv @@
package obb_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int TabLen = 24;
   localparam int CW = 34;
   localparam int ZW = 34;
   localparam logic signed [CW-1:0] CordicK0 = 34'sd652032874;
   localparam int Ppw = 48;

   localparam logic signed [23:0] S24Max = 24'sh7FFFFF;
   localparam logic signed [23:0] S24Min = -24'sh800000;

   // arctangent table in units of 2^-32 turn
   function automatic logic signed [ZW-1:0] atan_turn(input int i);
      logic signed [ZW-1:0] r;
      begin
         case (i)
            0: r = 34'sd536870912;
            1: r = 34'sd316933406;
            2: r = 34'sd167458907;
            3: r = 34'sd85004756;
            4: r = 34'sd42667331;
            5: r = 34'sd21354465;
            6: r = 34'sd10679838;
            7: r = 34'sd5340245;
            8: r = 34'sd2670163;
            9: r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   typedef struct packed {
      logic signed [23:0] a_x;
      logic signed [23:0] a_y;
      logic [15:0]        a_w;
      logic [15:0]        a_h;
      logic [15:0]        a_angle;
      logic signed [23:0] b_x;
      logic signed [23:0] b_y;
      logic [15:0]        b_w;
      logic [15:0]        b_h;
      logic [15:0]        b_angle;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [23:0] push_x;
      logic signed [23:0] push_y;
      logic signed [23:0] b_new_x;
      logic signed [23:0] b_new_y;
   } rsp_type;

endpackage

@@ sv/obb_req_if.sv @@
interface obb_req_if;
   logic              valid;
   logic              ready;
   obb_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/obb_rsp_if.sv @@
interface obb_rsp_if;
   logic              valid;
   logic              ready;
   obb_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/obb_collision_sat_mtv_core.sv @@
// Oriented-rectangle collision core (separating axis test with minimum push).
// Requests arrive on req (obb_req_if sink): two boxes, each a Q16.8 centre,
// Q8.8 width and height and a 16-bit binary heading. Results leave on rsp
// (obb_rsp_if source): hit flag, push vector and the pushed second centre.
// A request is accepted when valid and ready are both high at a clock edge.
// One request per cycle is taken in steady state while rsp is not stalled.
// Pipeline length varies with CORDIC_STEPS: a heading reduction stage, the
// CORDIC, one micro-rotation per stage up to the 24-entry table, then
// quadrant, corner, projection, axis select and push stages.
// The whole pipeline advances only when its last stage is free or taken, so
// a stalled receiver freezes every stage in place and req.ready drops; no
// request is lost or repeated. Synchronous reset clears all valid bits.
module obb_collision_sat_mtv_core #(
   parameter int CORDIC_STEPS = obb_pkg::CordicStepsDefault
) (
   input  logic  clock,
   input  logic  reset,
   obb_req_if.sink   req,
   obb_rsp_if.source rsp
);
   localparam int NS = CORDIC_STEPS;
   localparam int CW = obb_pkg::CW;
   localparam int ZW = obb_pkg::ZW;
   localparam int PW = obb_pkg::Ppw;

   logic adv;
   logic last_v;
   assign last_v = rsp.valid;
   assign adv = !last_v || rsp.ready;
   assign req.ready = adv;

   // ---------------- stage 0: heading reduction
   logic v0_ff;
   obb_pkg::req_type r0_ff;
   logic [1:0] qa0_ff, qb0_ff;
   logic signed [ZW-1:0] za0_ff, zb0_ff;

   function automatic logic [ZW+1:0] reduce(input logic [15:0] a);
      logic [1:0] q;
      logic signed [15:0] r;
      begin
         q = a[15:14];
         r = $signed({2'b00, a[13:0]});
         if (a[13]) begin
            r = r - 16'sh4000;
            q = q + 2'd1;
         end
         return {q, ZW'(r) <<< 16};
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req.valid;
      if (adv) begin
         r0_ff <= req.payload;
         {qa0_ff, za0_ff} <= reduce(req.payload.a_angle);
         {qb0_ff, zb0_ff} <= reduce(req.payload.b_angle);
      end
   end

   // ---------------- cordic stages, one rotation per stage within the table
   logic v_c_ff [NS+1];
   obb_pkg::req_type r_c_ff [NS+1];
   logic [1:0] qa_c_ff [NS+1], qb_c_ff [NS+1];
   logic signed [CW-1:0] xa_ff [NS+1], ya_ff [NS+1], xb_ff [NS+1], yb_ff [NS+1];
   logic signed [ZW-1:0] za_ff [NS+1], zb_ff [NS+1];

   always_comb begin
      v_c_ff[0] = v0_ff; r_c_ff[0] = r0_ff;
      qa_c_ff[0] = qa0_ff; qb_c_ff[0] = qb0_ff;
      xa_ff[0] = obb_pkg::CordicK0; ya_ff[0] = '0; za_ff[0] = za0_ff;
      xb_ff[0] = obb_pkg::CordicK0; yb_ff[0] = '0; zb_ff[0] = zb0_ff;
   end

   genvar gi;
   generate
      for (gi = 0; gi < NS; gi++) begin : g_cordic
         logic signed [ZW-1:0] at;
         assign at = (gi < obb_pkg::TabLen) ? obb_pkg::atan_turn(gi) : '0;
         always_ff @(posedge clock) begin
            if (reset) v_c_ff[gi+1] <= 1'b0;
            else if (adv) v_c_ff[gi+1] <= v_c_ff[gi];
            if (adv) begin
               r_c_ff[gi+1] <= r_c_ff[gi];
               qa_c_ff[gi+1] <= qa_c_ff[gi];
               qb_c_ff[gi+1] <= qb_c_ff[gi];
               if (gi >= obb_pkg::TabLen) begin
                  xa_ff[gi+1] <= xa_ff[gi]; ya_ff[gi+1] <= ya_ff[gi];
                  za_ff[gi+1] <= za_ff[gi];
                  xb_ff[gi+1] <= xb_ff[gi]; yb_ff[gi+1] <= yb_ff[gi];
                  zb_ff[gi+1] <= zb_ff[gi];
               end else begin
                  if (!za_ff[gi][ZW-1]) begin
                     xa_ff[gi+1] <= xa_ff[gi] - (ya_ff[gi] >>> gi);
                     ya_ff[gi+1] <= ya_ff[gi] + (xa_ff[gi] >>> gi);
                     za_ff[gi+1] <= za_ff[gi] - at;
                  end else begin
                     xa_ff[gi+1] <= xa_ff[gi] + (ya_ff[gi] >>> gi);
                     ya_ff[gi+1] <= ya_ff[gi] - (xa_ff[gi] >>> gi);
                     za_ff[gi+1] <= za_ff[gi] + at;
                  end
                  if (!zb_ff[gi][ZW-1]) begin
                     xb_ff[gi+1] <= xb_ff[gi] - (yb_ff[gi] >>> gi);
                     yb_ff[gi+1] <= yb_ff[gi] + (xb_ff[gi] >>> gi);
                     zb_ff[gi+1] <= zb_ff[gi] - at;
                  end else begin
                     xb_ff[gi+1] <= xb_ff[gi] + (yb_ff[gi] >>> gi);
                     yb_ff[gi+1] <= yb_ff[gi] - (xb_ff[gi] >>> gi);
                     zb_ff[gi+1] <= zb_ff[gi] + at;
                  end
               end
            end
         end
      end
   endgenerate

   // ---------------- post stage 1: round to Q.14 and apply quadrant
   function automatic logic [35:0] quad(input logic [1:0] q,
                                        input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y);
      logic signed [CW-1:0] xr, yr;
      logic signed [17:0] c, s, oc, os;
      begin
         xr = (x + CW'(32768)) >>> 16;
         yr = (y + CW'(32768)) >>> 16;
         c = xr[17:0]; s = yr[17:0];
         case (q)
            2'd0: begin oc = c; os = s; end
            2'd1: begin oc = -s; os = c; end
            2'd2: begin oc = -c; os = -s; end
            default: begin oc = s; os = -c; end
         endcase
         return {oc, os};
      end
   endfunction

   logic v1_ff; obb_pkg::req_type r1_ff;
   logic signed [17:0] adx1_ff, ady1_ff, bdx1_ff, bdy1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= v_c_ff[NS];
      if (adv) begin
         r1_ff <= r_c_ff[NS];
         {adx1_ff, ady1_ff} <= quad(qa_c_ff[NS], xa_ff[NS], ya_ff[NS]);
         {bdx1_ff, bdy1_ff} <= quad(qb_c_ff[NS], xb_ff[NS], yb_ff[NS]);
      end
   end

   // ---------------- post stage 2: half extent products
   logic v2_ff; obb_pkg::req_type r2_ff;
   logic signed [17:0] adx2_ff, ady2_ff, bdx2_ff, bdy2_ff;
   logic signed [35:0] aux_ff, auy_ff, ahx_ff, ahy_ff;
   logic signed [35:0] bux_ff, buy_ff, bhx_ff, bhy_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         r2_ff <= r1_ff;
         adx2_ff <= adx1_ff; ady2_ff <= ady1_ff;
         bdx2_ff <= bdx1_ff; bdy2_ff <= bdy1_ff;
         aux_ff <= adx1_ff * $signed({2'b00, r1_ff.a_w});
         auy_ff <= ady1_ff * $signed({2'b00, r1_ff.a_w});
         ahx_ff <= ady1_ff * $signed({2'b00, r1_ff.a_h});
         ahy_ff <= -(adx1_ff * $signed({2'b00, r1_ff.a_h}));
         bux_ff <= bdx1_ff * $signed({2'b00, r1_ff.b_w});
         buy_ff <= bdy1_ff * $signed({2'b00, r1_ff.b_w});
         bhx_ff <= bdy1_ff * $signed({2'b00, r1_ff.b_h});
         bhy_ff <= -(bdx1_ff * $signed({2'b00, r1_ff.b_h}));
      end
   end

   // ---------------- post stage 3: corners in Q.23
   logic v3_ff; obb_pkg::req_type r3_ff;
   logic signed [17:0] ax3_ff [4], ay3_ff [4];
   logic signed [40:0] acx_ff [4], acy_ff [4], bcx_ff [4], bcy_ff [4];
   logic signed [40:0] apx, apy, bpx, bpy;
   assign apx = 41'(r2_ff.a_x) <<< 15;
   assign apy = 41'(r2_ff.a_y) <<< 15;
   assign bpx = 41'(r2_ff.b_x) <<< 15;
   assign bpy = 41'(r2_ff.b_y) <<< 15;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         r3_ff <= r2_ff;
         ax3_ff[0] <= adx2_ff;  ay3_ff[0] <= ady2_ff;
         ax3_ff[1] <= -ady2_ff; ay3_ff[1] <= adx2_ff;
         ax3_ff[2] <= bdx2_ff;  ay3_ff[2] <= bdy2_ff;
         ax3_ff[3] <= -bdy2_ff; ay3_ff[3] <= bdx2_ff;
         acx_ff[0] <= apx - 41'(aux_ff) + 41'(ahx_ff);
         acy_ff[0] <= apy - 41'(auy_ff) + 41'(ahy_ff);
         acx_ff[1] <= apx + 41'(aux_ff) + 41'(ahx_ff);
         acy_ff[1] <= apy + 41'(auy_ff) + 41'(ahy_ff);
         acx_ff[2] <= apx + 41'(aux_ff) - 41'(ahx_ff);
         acy_ff[2] <= apy + 41'(auy_ff) - 41'(ahy_ff);
         acx_ff[3] <= apx - 41'(aux_ff) - 41'(ahx_ff);
         acy_ff[3] <= apy - 41'(auy_ff) - 41'(ahy_ff);
         bcx_ff[0] <= bpx - 41'(bux_ff) + 41'(bhx_ff);
         bcy_ff[0] <= bpy - 41'(buy_ff) + 41'(bhy_ff);
         bcx_ff[1] <= bpx + 41'(bux_ff) + 41'(bhx_ff);
         bcy_ff[1] <= bpy + 41'(buy_ff) + 41'(bhy_ff);
         bcx_ff[2] <= bpx + 41'(bux_ff) - 41'(bhx_ff);
         bcy_ff[2] <= bpy + 41'(buy_ff) - 41'(bhy_ff);
         bcx_ff[3] <= bpx - 41'(bux_ff) - 41'(bhx_ff);
         bcy_ff[3] <= bpy - 41'(buy_ff) - 41'(bhy_ff);
      end
   end

   // ---------------- post stage 4: axis-times-coordinate products
   logic v4_ff; obb_pkg::req_type r4_ff;
   logic signed [17:0] ax4_ff [4], ay4_ff [4];
   logic signed [58:0] pax_ff [4][4], pay_ff [4][4], pbx_ff [4][4], pby_ff [4][4];
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         r4_ff <= r3_ff;
         for (int k = 0; k < 4; k++) begin
            ax4_ff[k] <= ax3_ff[k]; ay4_ff[k] <= ay3_ff[k];
            for (int c = 0; c < 4; c++) begin
               pax_ff[k][c] <= ax3_ff[k] * acx_ff[c];
               pay_ff[k][c] <= ay3_ff[k] * acy_ff[c];
               pbx_ff[k][c] <= ax3_ff[k] * bcx_ff[c];
               pby_ff[k][c] <= ay3_ff[k] * bcy_ff[c];
            end
         end
      end
   end

   // ---------------- post stage 5: projections
   logic v5_ff; obb_pkg::req_type r5_ff;
   logic signed [17:0] ax5_ff [4], ay5_ff [4];
   logic signed [PW+11:0] pa_ff [4][4], pb_ff [4][4];
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         r5_ff <= r4_ff;
         for (int k = 0; k < 4; k++) begin
            ax5_ff[k] <= ax4_ff[k]; ay5_ff[k] <= ay4_ff[k];
            for (int c = 0; c < 4; c++) begin
               pa_ff[k][c] <= (PW+12)'(pax_ff[k][c]) + (PW+12)'(pay_ff[k][c]);
               pb_ff[k][c] <= (PW+12)'(pbx_ff[k][c]) + (PW+12)'(pby_ff[k][c]);
            end
         end
      end
   end

   // ---------------- post stage 6: min and max per axis
   localparam int QW = PW + 12;
   logic v6_ff; obb_pkg::req_type r6_ff;
   logic signed [17:0] ax6_ff [4], ay6_ff [4];
   logic signed [QW-1:0] s1mn_ff [4], s1mx_ff [4], s2mn_ff [4], s2mx_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         r6_ff <= r5_ff;
         for (int k = 0; k < 4; k++) begin
            logic signed [QW-1:0] m1, x1, m2, x2;
            ax6_ff[k] <= ax5_ff[k]; ay6_ff[k] <= ay5_ff[k];
            m1 = pa_ff[k][0]; x1 = pa_ff[k][0];
            m2 = pb_ff[k][0]; x2 = pb_ff[k][0];
            for (int c = 1; c < 4; c++) begin
               if (pa_ff[k][c] < m1) m1 = pa_ff[k][c];
               if (pa_ff[k][c] > x1) x1 = pa_ff[k][c];
               if (pb_ff[k][c] < m2) m2 = pb_ff[k][c];
               if (pb_ff[k][c] > x2) x2 = pb_ff[k][c];
            end
            s1mn_ff[k] <= m1; s1mx_ff[k] <= x1;
            s2mn_ff[k] <= m2; s2mx_ff[k] <= x2;
         end
      end
   end

   // ---------------- post stage 7: separation and signed depth per axis
   logic v7_ff; obb_pkg::req_type r7_ff;
   logic signed [17:0] ax7_ff [4], ay7_ff [4];
   logic [3:0] sep7_ff;
   logic signed [QW-1:0] d7_ff [4], m7_ff [4];
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
      if (adv) begin
         r7_ff <= r6_ff;
         for (int k = 0; k < 4; k++) begin
            logic signed [QW-1:0] d;
            ax7_ff[k] <= ax6_ff[k]; ay7_ff[k] <= ay6_ff[k];
            sep7_ff[k] <= (s2mn_ff[k] > s1mx_ff[k]) || (s2mx_ff[k] < s1mn_ff[k]);
            d = (s1mx_ff[k] > s2mx_ff[k]) ? (s1mn_ff[k] - s2mx_ff[k])
                                          : (s1mx_ff[k] - s2mn_ff[k]);
            d7_ff[k] <= d;
            m7_ff[k] <= d[QW-1] ? -d : d;
         end
      end
   end

   // ---------------- post stage 8: pick smallest depth, round to Q.22
   logic v8_ff, hit8_ff; obb_pkg::req_type r8_ff;
   logic signed [17:0] bax8_ff, bay8_ff;
   logic signed [QW-1:0] bd8_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
      if (adv) begin
         logic signed [QW-1:0] best, bd;
         logic signed [17:0] bx, by;
         r8_ff <= r7_ff;
         hit8_ff <= ~|sep7_ff;
         best = m7_ff[0]; bd = d7_ff[0]; bx = ax7_ff[0]; by = ay7_ff[0];
         for (int k = 1; k < 4; k++) begin
            if (m7_ff[k] < best) begin
               best = m7_ff[k]; bd = d7_ff[k]; bx = ax7_ff[k]; by = ay7_ff[k];
            end
         end
         bd8_ff <= (bd + QW'(16384)) >>> 15;
         bax8_ff <= bx; bay8_ff <= by;
      end
   end

   // ---------------- post stage 9: push product
   logic v9_ff, hit9_ff; obb_pkg::req_type r9_ff;
   logic signed [QW+17:0] prx9_ff, pry9_ff;
   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (adv) v9_ff <= v8_ff;
      if (adv) begin
         r9_ff <= r8_ff; hit9_ff <= hit8_ff;
         prx9_ff <= bd8_ff * bax8_ff;
         pry9_ff <= bd8_ff * bay8_ff;
      end
   end

   // ---------------- post stage 10: round, saturate and build result
   function automatic logic signed [23:0] sat24(input logic signed [QW+17:0] v);
      begin
         if (v > (QW+18)'(obb_pkg::S24Max)) return obb_pkg::S24Max;
         if (v < (QW+18)'(obb_pkg::S24Min)) return obb_pkg::S24Min;
         return v[23:0];
      end
   endfunction

   logic signed [QW+17:0] rx, ry;
   logic signed [23:0] psx, psy;
   assign rx = (prx9_ff + (QW+18)'(134217728)) >>> 28;
   assign ry = (pry9_ff + (QW+18)'(134217728)) >>> 28;
   assign psx = sat24(rx);
   assign psy = sat24(ry);

   logic rsp_valid_ff;
   obb_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v9_ff;
      if (adv) begin
         rsp_ff.hit <= hit9_ff;
         if (hit9_ff) begin
            rsp_ff.push_x <= psx;
            rsp_ff.push_y <= psy;
            rsp_ff.b_new_x <= sat24((QW+18)'(r9_ff.b_x) + (QW+18)'(psx));
            rsp_ff.b_new_y <= sat24((QW+18)'(r9_ff.b_y) + (QW+18)'(psy));
         end else begin
            rsp_ff.push_x <= '0;
            rsp_ff.push_y <= '0;
            rsp_ff.b_new_x <= r9_ff.b_x;
            rsp_ff.b_new_y <= r9_ff.b_y;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // ---------------- checks
`include "obb_collision_sat_mtv_core_defines.svh"
   `OBB_ASSERT_IMPL(a_stall_ready, clock, reset, rsp.valid && !rsp.ready, !req.ready, "ready while output stalled")
   `OBB_ASSERT_NEXT(a_stall_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload), "stalled result changed")
   `OBB_ASSERT_IMPL(a_miss_zero, clock, reset, rsp.valid && !rsp.payload.hit, rsp.payload.push_x == 24'sd0 && rsp.payload.push_y == 24'sd0, "push nonzero on miss")

endmodule
